>>> sv/radix_integer_to_text_macros.svh
// ----------------------------------------------------------------------------
// Radix integer-to-text assertion macros
// Shared wrappers for the concurrent checks of the conversion block.
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TO_TEXT_MACROS_SVH
`define RADIX_INTEGER_TO_TEXT_MACROS_SVH

// Check a property on every clock edge outside reset
`define RIT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define RIT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/rit_pkg.sv
// ----------------------------------------------------------------------------
// Radix integer-to-text package
// Fixed widths, character codes and register indexes of the converter.
// ----------------------------------------------------------------------------
package rit_pkg;

  // Field and register widths
  localparam int unsigned SYM_W        = 8;
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned RADIX_W      = 5;
  localparam int unsigned SYM_SLOTS    = 16;
  localparam int unsigned SYM_WORD_W   = 64;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned DIV_STEP_BITS = 8;

  // Character codes
  localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_SIZE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 8'd2;

  typedef logic [SYM_W-1:0] sym_t;

endpackage

>>> sv/radix_integer_to_text.sv
// ----------------------------------------------------------------------------
// Radix integer-to-text converter
// Turns one signed integer into its text in a radix set by a configured
// symbol alphabet: optional '-', then digits most significant first.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   handshake
//  -------   ---------------------------------------   ---------------------
//  input     value_i                                   start & !busy
//  output    character_o, last_o                       out_valid_o strobe
//  config    cfg_index_i, cfg_data_i                   cfg_valid_i & cfg_ready_o
//
// One word runs an alphabet check over the first n symbols (n = radix size),
// then the shared divider (8 quotient bits a cycle) for each digit, then the
// digit store read and the output register for each character.
// An invalid alphabet ends the word after the check with no output.
// Reset is asynchronous and active low; it clears control state and configuration registers only.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module radix_integer_to_text
  import rit_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned MAX_DIGITS  = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  output logic [SYM_W-1:0]       character_o,
  output logic                   last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned NCHUNK = (VALUE_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned PADW   = NCHUNK * DIV_STEP_BITS;
  localparam int unsigned CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_DIGITS);
  localparam int unsigned SIDX_W = $clog2(SYM_SLOTS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // Configuration registers
  logic [RADIX_W-1:0]    radix_q;
  logic [SYM_WORD_W-1:0] sym_low_q, sym_high_q;

  // Sequencer state
  logic [1:0]        state_q, state_d;
  logic [SIDX_W-1:0] sidx_q, sidx_d;
  logic [CHK_W-1:0]  chunk_q, chunk_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PADW-1:0]   mag_q, mag_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic              neg_q, neg_d;

  // Digit store and read stage
  logic [DIGIT_W-1:0] store_q [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_q;
  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic               rd_vld_q, rd_vld_d, rd_last_q, rd_last_d;

  // Output register
  logic               out_valid_q, out_valid_d, last_q, last_d;
  logic [SYM_W-1:0]   char_q, char_d;
  logic               minus_fire;

  sym_t               sym [SYM_SLOTS];
  logic               range_bad, sym_bad;
  logic [VALUE_WIDTH-1:0] abs_val;
  logic [PADW-1:0]    div_x;
  logic [DIGIT_W-1:0] div_r;

  assign busy        = (state_q != ST_IDLE) | rd_vld_q;
  assign cfg_ready_o = ~busy;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= '0;
      sym_low_q  <= '0;
      sym_high_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_RADIX_SIZE:   radix_q    <= cfg_data_i[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  sym_low_q  <= cfg_data_i;
        REG_SYMBOLS_HIGH: sym_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the alphabet
  always_comb begin
    for (int k = 0; k < SYM_SLOTS / 2; k++) begin
      sym[k]                 = sym_low_q[k*SYM_W +: SYM_W];
      sym[k + SYM_SLOTS / 2] = sym_high_q[k*SYM_W +: SYM_W];
    end
  end

  // Check the radix size, and one symbol against the reserved codes and all later symbols of the radix
  always_comb begin
    range_bad = (radix_q < RADIX_W'(2)) || (radix_q > RADIX_W'(MAX_SYMBOLS));
    sym_bad   = (sym[sidx_q] == CHAR_NUL) || (sym[sidx_q] == CHAR_PLUS) ||
                (sym[sidx_q] == CHAR_MINUS);
    for (int b = 0; b < SYM_SLOTS; b++) begin
      if ((RADIX_W'(b) > {1'b0, sidx_q}) && (RADIX_W'(b) < radix_q) &&
          (sym[b] == sym[sidx_q])) begin
        sym_bad = 1'b1;
      end
    end
  end

  // Magnitude, unsigned and wide enough for the most negative value
  assign abs_val = value_i[VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i;

  // Shared divider: eight restoring steps of magnitude by radix
  always_comb begin
    logic [DIGIT_W:0] r2;
    div_x = mag_q;
    div_r = rem_q;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      r2    = {div_r, div_x[PADW-1]};
      div_x = {div_x[PADW-2:0], 1'b0};
      if (r2 >= radix_q) begin
        r2       = r2 - radix_q;
        div_x[0] = 1'b1;
      end
      div_r = r2[DIGIT_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    sidx_d     = sidx_q;
    chunk_d    = chunk_q;
    cnt_d      = cnt_q;
    mag_d      = mag_q;
    rem_d      = rem_q;
    neg_d      = neg_q;
    minus_fire = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cnt_q[ADDR_W-1:0];
    rd_en      = 1'b0;
    rd_addr    = ADDR_W'(cnt_q - CNT_W'(1));
    rd_vld_d   = 1'b0;
    rd_last_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start && !busy) begin
          state_d = ST_CHECK;
          sidx_d  = '0;
          mag_d   = PADW'(abs_val);
          neg_d   = value_i[VALUE_WIDTH-1];
        end
      end
      ST_CHECK: begin
        if (range_bad || sym_bad) begin
          state_d = ST_IDLE;
        end else if ({1'b0, sidx_q} == radix_q - RADIX_W'(1)) begin
          state_d    = ST_DIV;
          minus_fire = neg_q;
          chunk_d    = '0;
          rem_d      = '0;
          cnt_d      = '0;
        end else begin
          sidx_d = sidx_q + SIDX_W'(1);
        end
      end
      ST_DIV: begin
        mag_d = div_x;
        rem_d = div_r;
        if (chunk_q == CHK_W'(NCHUNK - 1)) begin
          // Store the digit and decide whether another one follows
          wr_en   = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
          chunk_d = '0;
          rem_d   = '0;
          if ((div_x == '0) || (cnt_q >= CNT_W'(MAX_DIGITS - 1))) begin
            state_d = ST_EMIT;
          end
        end else begin
          chunk_d = chunk_q + CHK_W'(1);
        end
      end
      ST_EMIT: begin
        rd_en     = 1'b1;
        rd_vld_d  = 1'b1;
        rd_last_d = (cnt_q == CNT_W'(1));
        cnt_d     = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sidx_q    <= '0;
      chunk_q   <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      neg_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      sidx_q    <= sidx_d;
      chunk_q   <= chunk_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      neg_q     <= neg_d;
    end
  end

  // Datapath registers hold without reset
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

  // Digit store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[wr_addr] <= div_r;
    if (rd_en) rd_data_q <= store_q[rd_addr];
  end

  // Output word: sign first, then looked-up symbols
  assign out_valid_d = rd_vld_q | minus_fire;
  assign char_d      = minus_fire ? CHAR_MINUS : sym[rd_data_q];
  assign last_d      = rd_vld_q & rd_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // Checks
`include "radix_integer_to_text_macros.svh"

  `RIT_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `RIT_ASSERT(a_read_busy, rd_vld_q |-> busy, "digit read in flight while not busy")
  `RIT_ASSERT(a_last_gap, (out_valid_o && last_o) |=> !out_valid_o, "word after last marker")
  `RIT_ASSERT(a_minus_not_last, (out_valid_o && character_o == CHAR_MINUS) |-> !last_o, "sign ended a text")
  `RIT_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_W'(MAX_DIGITS), "digit count out of range")

endmodule
